### design/tvws_pkg.sv
// Shared constants for the tagged variable-width byte stack.
// No dependencies; used by the stack core.
`default_nettype none

package tvws_pkg;

  // Default capacity of the byte store
  localparam int unsigned STACK_BYTES_DEF = 1024;

  // Largest value in bytes
  localparam int unsigned MAX_VALUE_BYTES = 8;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned WIDTH_W  = 4;
  localparam int unsigned STATUS_W = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

  // Request kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

endpackage

`default_nettype wire

### design/tvws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced by the stack core as the byte store.
`default_nettype none

module tvws_ram #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [DataWidth-1:0]     wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [DataWidth-1:0]     rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/tagged_variable_width_stack_core.sv
// Tagged variable-width byte stack: top level with sequencer and output register.
// Depends on tvws_pkg for constants and tvws_ram for the byte store.
//
// Byte-wide stack of STACK_BYTES bytes holding values of 1 to 8 bytes, each
// followed by a tag byte with its width. One request is worked at a time
// through the byte-wide store: a push writes one byte per value byte and
// then the tag, a pop reads the tag, checks it and then reads one byte per
// value byte, and a rejected request goes straight to its result. in_stall_o
// is high while a request is in work or its result waits for the output
// register; a result in the output register waits there, and the next
// request is taken meanwhile. No clearing pass follows reset.
`default_nettype none

module tagged_variable_width_stack_core #(
  parameter int unsigned STACK_BYTES = tvws_pkg::STACK_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           kind_i,
  input  wire logic [tvws_pkg::VALUE_W-1:0]   value_i,
  input  wire logic [tvws_pkg::WIDTH_W-1:0]   width_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [tvws_pkg::VALUE_W-1:0]   result_value_o,
  output logic      [tvws_pkg::WIDTH_W-1:0]   stored_width_o,
  output logic      [tvws_pkg::STATUS_W-1:0]  status_o
);

  localparam int unsigned AW = $clog2(STACK_BYTES);
  localparam int unsigned FW = $clog2(STACK_BYTES + 1);
  localparam int unsigned CW = FW + tvws_pkg::BYTE_W;
  localparam int unsigned VW = tvws_pkg::VALUE_W;
  localparam int unsigned WW = tvws_pkg::WIDTH_W;
  localparam int unsigned BW = tvws_pkg::BYTE_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PUSH    = 3'd1;
  localparam logic [2:0] ST_POP_CHK = 3'd2;
  localparam logic [2:0] ST_POP_RD  = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [FW-1:0]                  fill_q, fill_d;
  logic                           out_valid_q, out_valid_d;

  logic [AW-1:0]                  ptr_q, ptr_d;
  logic [WW-1:0]                  cnt_q, cnt_d;
  logic [WW-1:0]                  wid_q, wid_d;
  logic [VW-1:0]                  val_q, val_d;
  logic [VW-1:0]                  res_value_q, res_value_d;
  logic [WW-1:0]                  res_width_q, res_width_d;
  logic [tvws_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic [VW-1:0]                  out_value_q, out_value_d;
  logic [WW-1:0]                  out_width_q, out_width_d;
  logic [tvws_pkg::STATUS_W-1:0]  out_status_q, out_status_d;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [BW-1:0]                  mem_wdata;
  logic [AW-1:0]                  mem_raddr;
  logic [BW-1:0]                  mem_rdata;

  logic                           accept;
  logic                           out_free;
  logic [WW-1:0]                  push_w;
  logic [FW-1:0]                  room;
  logic [FW-1:0]                  below;
  logic                           tag_bad;

  tvws_ram #(
    .DataWidth (BW),
    .Depth     (STACK_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Clamp push width to 1..8
  always_comb begin
    priority if (width_i == '0) begin
      push_w = WW'(1);
    end else if (width_i > WW'(tvws_pkg::MAX_VALUE_BYTES)) begin
      push_w = WW'(tvws_pkg::MAX_VALUE_BYTES);
    end else begin
      push_w = width_i;
    end
  end

  assign room  = FW'(STACK_BYTES) - fill_q;
  assign below = fill_q - FW'(1);

  // Tag sits in mem_rdata the cycle after acceptance
  assign tag_bad = (mem_rdata > BW'(wid_q)) || (mem_rdata == '0) ||
                   (mem_rdata > BW'(tvws_pkg::MAX_VALUE_BYTES)) ||
                   (CW'(mem_rdata) > CW'(below));

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    wid_d        = wid_q;
    val_d        = val_q;
    res_value_d  = res_value_q;
    res_width_d  = res_width_q;
    res_status_d = res_status_q;
    out_value_d  = out_value_q;
    out_width_d  = out_width_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = ptr_q;
    mem_wdata    = val_q[BW-1:0];
    mem_raddr    = below[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        // Read the top tag speculatively every idle cycle
        mem_raddr = below[AW-1:0];
        if (accept) begin
          res_value_d = '0;
          res_width_d = '0;
          cnt_d       = '0;
          ptr_d       = fill_q[AW-1:0];
          val_d       = value_i;
          if (kind_i == tvws_pkg::KIND_PUSH) begin
            wid_d = push_w;
            if (room < FW'(push_w) + FW'(1)) begin
              res_status_d = tvws_pkg::STATUS_OVERFLOW;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_PUSH;
            end
          end else begin
            wid_d = width_i;
            if (fill_q == '0) begin
              res_status_d = tvws_pkg::STATUS_EMPTY;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_POP_CHK;
            end
          end
        end
      end

      ST_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        if (cnt_q == wid_q) begin
          mem_wdata    = BW'(wid_q);
          fill_d       = FW'(ptr_q) + FW'(1);
          res_status_d = tvws_pkg::STATUS_OK;
          state_d      = ST_DONE;
        end else begin
          mem_wdata = val_q[BW-1:0];
          val_d     = val_q >> BW;
          ptr_d     = ptr_q + AW'(1);
          cnt_d     = cnt_q + WW'(1);
        end
      end

      ST_POP_CHK: begin
        res_width_d = mem_rdata[WW-1:0];
        if (tag_bad) begin
          res_status_d = tvws_pkg::STATUS_MISMATCH;
          state_d      = ST_DONE;
        end else begin
          // Start at the top value byte (most significant) and walk down
          mem_raddr   = AW'(below - FW'(1));
          ptr_d       = AW'(below - FW'(1));
          cnt_d       = mem_rdata[WW-1:0];
          res_value_d = '0;
          state_d     = ST_POP_RD;
        end
      end

      ST_POP_RD: begin
        res_value_d = {res_value_q[VW-BW-1:0], mem_rdata};
        if (cnt_q == WW'(1)) begin
          fill_d       = FW'(ptr_q);
          res_status_d = tvws_pkg::STATUS_OK;
          state_d      = ST_DONE;
        end else begin
          mem_raddr = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
          cnt_d     = cnt_q - WW'(1);
        end
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_width_d  = res_width_q;
          out_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    cnt_q        <= cnt_d;
    wid_q        <= wid_d;
    val_q        <= val_d;
    res_value_q  <= res_value_d;
    res_width_q  <= res_width_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_width_q  <= out_width_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign stored_width_o = out_width_q;
  assign status_o       = out_status_q;

endmodule

`default_nettype wire
